[hw/rtl/tkcl_pkg.sv]
// Shared types and constants of the top-k candidate list picker.
package tkcl_pkg;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned COST_W  = 32;
   localparam int unsigned FRAC_W  = 17;
   localparam int unsigned CNT_W   = 4;   // holds a count up to fifteen
   localparam int unsigned NUM_THR = 4;   // number of threshold registers
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [FRAC_W-1:0] THR_ONE = 17'h10000;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_PICK   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Word that travels down the row of cells, one cell per cycle.
   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     id;      // carried candidate id
      logic [COST_W-1:0]   cost;    // carried candidate cost
      logic                cvalid;  // carried candidate still looking for a place
      logic                displaced; // carried candidate was pushed out of an earlier slot
      logic [FRAC_W-1:0]   draw;
      logic                found;
      logic [ID_W-1:0]     picked;
      logic [ID_W-1:0]     last;
      logic                any;
      logic [CNT_W-1:0]    count;
   } token_type;

endpackage

[hw/rtl/tkcl_cell.sv]
// One list slot: holds an entry and works on the word passing through it.
module tkcl_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            thr_en,
   input  logic [tkcl_pkg::FRAC_W-1:0]     thr,
   input  logic                            tok_v,
   input  tkcl_pkg::token_type             tok,
   output logic                            tok_v_out,
   output tkcl_pkg::token_type             tok_out
);

   logic                          valid_ff, valid_in;
   logic [tkcl_pkg::ID_W-1:0]     id_ff, id_in;
   logic [tkcl_pkg::COST_W-1:0]   cost_ff, cost_in;
   logic                          tok_v_ff;
   tkcl_pkg::token_type           tok_ff, tok_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      cost_in  = cost_ff;
      tok_in   = tok;
      if (tok_v) begin
         case (tok.op)
            tkcl_pkg::OP_INSERT: begin
               // take the carried candidate if the slot is free, it is strictly cheaper,
               // or it was pushed out of an earlier slot (shift the tail down one place)
               if (tok.cvalid && (!valid_ff || tok.displaced || (tok.cost < cost_ff))) begin
                  valid_in         = 1'b1;
                  id_in            = tok.id;
                  cost_in          = tok.cost;
                  tok_in.id        = id_ff;
                  tok_in.cost      = cost_ff;
                  tok_in.cvalid    = valid_ff;
                  tok_in.displaced = 1'b1;
               end
            end
            tkcl_pkg::OP_PICK: begin
               if (valid_ff) begin
                  tok_in.last = id_ff;
                  tok_in.any  = 1'b1;
                  if (thr_en && !tok.found && (tok.draw <= thr)) begin
                     tok_in.found  = 1'b1;
                     tok_in.picked = id_ff;
                  end
               end
            end
            tkcl_pkg::OP_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
         tok_in.count = tok.count + {{(tkcl_pkg::CNT_W-1){1'b0}}, valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_v_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_v_ff <= tok_v;
      end
      id_ff   <= id_in;
      cost_ff <= cost_in;
      tok_ff  <= tok_in;
   end

   assign tok_v_out = tok_v_ff;
   assign tok_out   = tok_ff;

endmodule

[hw/rtl/top_k_candidate_list_picker.sv]
// Top level of the top-k candidate list picker: row of slot cells, thresholds, result register.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  opcode, candidate_id, candidate_cost, random_draw
//   rsp_     out        rsp_valid / rsp_stall  picked_id, list_empty, stored_count
//   csr_     in         csr_valid / csr_ready  csr_index, csr_data (threshold registers)
//
// One word at a time: an accepted word walks the row of LIST_SIZE cells, one cell a
// cycle, then waits in a pending register before the result register; a new word is
// taken only once the pending word has moved on into the result register.
// Reset empties the list, sets every threshold to one and clears the valid and busy flags; payloads are not cleared.
// A stalled result holds in its register while the next word is already walking.
module top_k_candidate_list_picker #(
   parameter int unsigned LIST_SIZE = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_opcode,
   input  logic [tkcl_pkg::ID_W-1:0]          req_candidate_id,
   input  logic [tkcl_pkg::COST_W-1:0]        req_candidate_cost,
   input  logic [tkcl_pkg::FRAC_W-1:0]        req_random_draw,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tkcl_pkg::ID_W-1:0]          rsp_picked_id,
   output logic                               rsp_list_empty,
   output logic [2:0]                         rsp_stored_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tkcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tkcl_pkg::FRAC_W-1:0]        csr_data
);

   // threshold registers
   logic [tkcl_pkg::FRAC_W-1:0] thr_ff [tkcl_pkg::NUM_THR];

   // word path through the cells; index 0 is the entry register
   logic                  tok_v [LIST_SIZE+1];
   tkcl_pkg::token_type   tok   [LIST_SIZE+1];
   logic                  tok0_v_ff;
   tkcl_pkg::token_type   tok0_ff, tok0_in;

   logic                  busy_ff;
   logic                  pend_v_ff;
   tkcl_pkg::token_type   pend_ff;
   logic                  rsp_valid_ff;
   logic [tkcl_pkg::ID_W-1:0] rsp_picked_id_ff, rsp_picked_id_in;
   logic                  rsp_list_empty_ff, rsp_list_empty_in;
   logic [2:0]            rsp_stored_count_ff;

   logic                  req_take;
   logic                  rsp_free;
   logic                  pend_move;
   logic [LIST_SIZE:0]    tok_v_vec;

   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_move = pend_v_ff && rsp_free;
   assign csr_ready = 1'b1;

   // build the word that enters the first cell
   always_comb begin
      tok0_in        = '0;
      tok0_in.op     = tkcl_pkg::op_type'(req_opcode);
      tok0_in.id     = req_candidate_id;
      tok0_in.cost   = req_candidate_cost;
      tok0_in.draw   = req_random_draw;
      tok0_in.cvalid = (tkcl_pkg::op_type'(req_opcode) == tkcl_pkg::OP_INSERT);
   end

   assign tok_v[0] = tok0_v_ff;
   assign tok[0]   = tok0_ff;

   for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
      logic                        thr_en;
      logic [tkcl_pkg::FRAC_W-1:0] thr;
      if (i < tkcl_pkg::NUM_THR) begin : g_thr
         assign thr_en = 1'b1;
         assign thr    = thr_ff[i];
      end else begin : g_nothr
         // slots past the threshold registers are only ever picked as the last entry
         assign thr_en = 1'b0;
         assign thr    = '0;
      end
      tkcl_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .thr_en    (thr_en),
         .thr       (thr),
         .tok_v     (tok_v[i]),
         .tok       (tok[i]),
         .tok_v_out (tok_v[i+1]),
         .tok_out   (tok[i+1])
      );
      assign tok_v_vec[i] = tok_v[i];
   end
   assign tok_v_vec[LIST_SIZE] = tok_v[LIST_SIZE];

   // resolve the pick from the finished word
   always_comb begin
      rsp_picked_id_in  = '0;
      rsp_list_empty_in = 1'b0;
      if (pend_ff.op == tkcl_pkg::OP_PICK) begin
         if (!pend_ff.any) begin
            rsp_list_empty_in = 1'b1;
         end else if (pend_ff.found) begin
            rsp_picked_id_in = pend_ff.picked;
         end else begin
            rsp_picked_id_in = pend_ff.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tkcl_pkg::NUM_THR; i++) begin
            thr_ff[i] <= tkcl_pkg::THR_ONE;
         end
         tok0_v_ff    <= 1'b0;
         busy_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop writes beyond the threshold registers
         if (csr_valid && (csr_index < tkcl_pkg::CSR_IDX_W'(tkcl_pkg::NUM_THR))) begin
            thr_ff[csr_index[1:0]] <= csr_data;
         end
         tok0_v_ff <= req_take;
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (pend_move) begin
            busy_ff <= 1'b0;
         end
         if (tok_v[LIST_SIZE]) begin
            pend_v_ff <= 1'b1;
         end else if (pend_move) begin
            pend_v_ff <= 1'b0;
         end
         if (pend_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         tok0_ff <= tok0_in;
      end
      if (tok_v[LIST_SIZE]) begin
         pend_ff <= tok[LIST_SIZE];
      end
      if (pend_move) begin
         rsp_picked_id_ff    <= rsp_picked_id_in;
         rsp_list_empty_ff   <= rsp_list_empty_in;
         rsp_stored_count_ff <= pend_ff.count[2:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_id    = rsp_picked_id_ff;
   assign rsp_list_empty   = rsp_list_empty_ff;
   assign rsp_stored_count = rsp_stored_count_ff;

   // at most one word walks the row at any time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_v_vec))
      else $error("more than one word in the cell row");

   // a word in the row or pending always keeps the input stalled
   a_busy_cover: assert property (@(posedge clock) disable iff (reset)
      ((tok_v_vec != '0) || pend_v_ff) |-> busy_ff)
      else $error("word in flight while input open");

   // an accepted word reaches the end of the row, passing the entry register and every cell
   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ##(LIST_SIZE+1) tok_v[LIST_SIZE])
      else $error("word lost in the cell row");

   // the finished count never exceeds the list length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> (pend_ff.count <= tkcl_pkg::CNT_W'(LIST_SIZE)))
      else $error("stored count beyond list size");

   // a finished word never lands on a pending one that has not moved on
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      tok_v[LIST_SIZE] |-> !pend_v_ff)
      else $error("pending word overwritten");

endmodule
